// ----- src/sorted_timer_event_queue_assert.svh -----
// Assertion macros shared by the checker of the sorted timer event queue.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SORTED_TIMER_EVENT_QUEUE_ASSERT_SVH
`define SORTED_TIMER_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define STQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stq check failed");

// Next-cycle implication, disabled while reset is held.
`define STQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stq check failed");

`endif

// ----- src/stq_pkg.sv -----
// Shared types and constants of the sorted timer event queue.
// No dependencies; every module of the block imports it.
`default_nettype none

package stq_pkg;

  // One stored queue entry.
  typedef struct packed {
    logic [63:0] deadline;
    logic [7:0]  tag;
  } stq_entry_t;

  // Enables of the deadline unit's two stages.
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } stq_dl_ctl_t;

  // Input command codes.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_DROPPED    = 3'd1;
  localparam logic [2:0] ST_NO_EXPIRY  = 3'd2;
  localparam logic [2:0] ST_FIRED      = 3'd3;
  localparam logic [2:0] ST_IDLE_REARM = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_TICKS_PER_SECOND = 1'b0;
  localparam logic CFG_IDLE_TIMEOUT     = 1'b1;

  // Configuration reset values.
  localparam logic [31:0] TPS_RESET  = 32'd62500000;
  localparam logic [15:0] IDLE_RESET = 16'd30;

endpackage

`default_nettype wire

// ----- src/stq_ram.sv -----
// Entry store of the sorted timer event queue: one write and one read port.
// Read data is registered. Uses stq_pkg.
`default_nettype none

module stq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  stq_pkg::stq_entry_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output stq_pkg::stq_entry_t rd_data
);
  import stq_pkg::*;

  stq_entry_t mem [DEPTH];
  stq_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- src/stq_dl_unit.sv -----
// Deadline unit: base tick plus rate times seconds, in two registered stages.
// The 32x16 product is registered before the 64-bit add. Uses stq_pkg.
`default_nettype none

module stq_dl_unit (
  input  logic                 clk,
  input  stq_pkg::stq_dl_ctl_t ctl,
  input  logic [31:0]          rate,
  input  logic [15:0]          seconds,
  input  logic [63:0]          base,
  output logic [63:0]          deadline
);
  import stq_pkg::*;

  logic [47:0] prod_r;
  logic [63:0] dl_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= {16'd0, rate} * {32'd0, seconds};
    end
    if (ctl.add_en) begin
      dl_r <= base + {16'd0, prod_r};
    end
  end

  assign deadline = dl_r;

endmodule

`default_nettype wire

// ----- src/sorted_timer_event_queue.sv -----
// Sorted timer event queue. Each item goes from S_IDLE to S_DONE, which loads the output
// register: at once for a tick without expiry or a dropped add; via S_POP1, S_POP2 for a pop;
// via S_POP1, S_MUL, S_ADD, S_ARM for a pop that empties the queue; via S_MUL, S_ADD, S_ARM
// for an idle re-arm; for an add via S_MUL, S_ADD, S_ARM and the insertion walk over the memory:
// S_WALK shifts later entries back, S_PLACE writes a new head. A full output holds S_DONE.
// Synchronous active-low reset clears counter, compare value, count and loads register defaults.
`default_nettype none

module sorted_timer_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel. tdata: timeout_seconds [15:0], event_tag [23:16].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // tuser: cmd [0].
  input  logic [0:0]  in_tuser,
  // Result channel. tdata: fired_tag [7:0], armed_deadline [71:8],
  // pending_count [76:72], zero fill [79:77].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  // tuser: status [2:0].
  output logic [2:0]  out_tuser,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import stq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // The queue lives in the memory as a ring: position p of the sorted order sits at
  // address head + p, wrapped at the depth. Popping the head just moves head forward.
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_ADD   = 9'b000000100,
    S_ARM   = 9'b000001000,
    S_WALK  = 9'b000010000,
    S_PLACE = 9'b000100000,
    S_POP1  = 9'b001000000,
    S_POP2  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [31:0]   tps_r, tps_nxt;
  logic [15:0]   idle_r, idle_nxt;
  logic [63:0]   tick_r, tick_nxt;
  logic [63:0]   cmp_r, cmp_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [15:0]   sec_r, sec_nxt;
  logic [7:0]    tag_in_r, tag_in_nxt;
  logic          mode_add_r, mode_add_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [7:0]    res_tag_r, res_tag_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_tag_r, out_tag_nxt;
  logic [63:0]   out_dl_r, out_dl_nxt;
  logic [4:0]    out_count_r, out_count_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  stq_entry_t    wr_data, rd_data, new_entry;
  stq_dl_ctl_t   dl_ctl;
  logic [63:0]   dl;
  logic [63:0]   tick_inc;
  logic [CW+4:0] count_wide;

  // Address of a sorted position in the ring.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  stq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The multiplier stage runs in S_MUL and the add stage in S_ADD; the result then
  // holds steady through the walk because neither stage is enabled again.
  assign dl_ctl.mul_en = (state_r == S_MUL);
  assign dl_ctl.add_en = (state_r == S_ADD);

  stq_dl_unit u_dl (
    .clk      (clk),
    .ctl      (dl_ctl),
    .rate     (tps_r),
    .seconds  (sec_r),
    .base     (tick_r),
    .deadline (dl)
  );

  assign tick_inc           = tick_r + 64'd1;
  assign new_entry.deadline = dl;
  assign new_entry.tag      = tag_in_r;
  assign count_wide         = {5'd0, count_r};

  // Only one item is in work, so no read of an entry ever lands on the address
  // written in the cycle before; the walk writes position p while it reads p-2.
  always_comb begin
    state_nxt      = state_r;
    tps_nxt        = tps_r;
    idle_nxt       = idle_r;
    tick_nxt       = tick_r;
    cmp_nxt        = cmp_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    pos_nxt        = pos_r;
    sec_nxt        = sec_r;
    tag_in_nxt     = tag_in_r;
    mode_add_nxt   = mode_add_r;
    status_nxt     = status_r;
    res_tag_nxt    = res_tag_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_dl_nxt     = out_dl_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = ring_addr(head_r, pos_r);
    wr_data        = new_entry;
    rd_en          = 1'b0;
    rd_addr        = head_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_SECOND: tps_nxt = cfg_wdata;
        CFG_IDLE_TIMEOUT:     idle_nxt = cfg_wdata[15:0];
        default: ;
      endcase
    end

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_tag_nxt = 8'd0;
          if (in_tuser[0] == CMD_ADD) begin
            if (count_r == DEPTH_C) begin
              status_nxt = ST_DROPPED;
              state_nxt  = S_DONE;
            end else begin
              sec_nxt      = in_tdata[15:0];
              tag_in_nxt   = in_tdata[23:16];
              mode_add_nxt = 1'b1;
              status_nxt   = ST_ADDED;
              state_nxt    = S_MUL;
            end
          end else begin
            tick_nxt = tick_inc;
            if (tick_inc < cmp_r) begin
              status_nxt = ST_NO_EXPIRY;
              state_nxt  = S_DONE;
            end else if (count_r == '0) begin
              sec_nxt      = idle_r;
              mode_add_nxt = 1'b0;
              status_nxt   = ST_IDLE_REARM;
              state_nxt    = S_MUL;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head_r;
              status_nxt = ST_FIRED;
              state_nxt  = S_POP1;
            end
          end
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        state_nxt = S_ARM;
      end
      S_ARM: begin
        if (mode_add_r) begin
          // Start the walk from the tail, one past the last stored entry.
          pos_nxt = count_r[AW-1:0];
          if (count_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ring_addr(head_r, count_r[AW-1:0] - AW'(1));
            state_nxt = S_WALK;
          end
        end else begin
          cmp_nxt   = dl;
          state_nxt = S_DONE;
        end
      end
      S_WALK: begin
        // rd_data is the entry at position pos_r-1.
        wr_en   = 1'b1;
        wr_addr = ring_addr(head_r, pos_r);
        if (rd_data.deadline <= dl) begin
          // Lands behind an entry with an earlier or equal deadline, so the head and compare value stay.
          wr_data   = new_entry;
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          wr_data = rd_data;
          pos_nxt = pos_r - AW'(1);
          if (pos_r == AW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ring_addr(head_r, pos_r - AW'(2));
          end
        end
      end
      S_PLACE: begin
        // New head of the queue.
        wr_en     = 1'b1;
        wr_addr   = ring_addr(head_r, pos_r);
        wr_data   = new_entry;
        cmp_nxt   = dl;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_POP1: begin
        res_tag_nxt = rd_data.tag;
        if (count_r == CW'(1)) begin
          // Last event leaves: arm the idle timeout from the current tick.
          head_nxt     = ring_addr(head_r, AW'(1));
          count_nxt    = '0;
          sec_nxt      = idle_r;
          mode_add_nxt = 1'b0;
          state_nxt    = S_MUL;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ring_addr(head_r, AW'(1));
          state_nxt = S_POP2;
        end
      end
      S_POP2: begin
        cmp_nxt   = rd_data.deadline;
        head_nxt  = ring_addr(head_r, AW'(1));
        count_nxt = count_r - CW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_tag_nxt    = res_tag_r;
          out_dl_nxt     = cmp_r;
          out_count_nxt  = count_wide[4:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tps_r       <= TPS_RESET;
      idle_r      <= IDLE_RESET;
      tick_r      <= '0;
      cmp_r       <= '0;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tps_r       <= tps_nxt;
      idle_r      <= idle_nxt;
      tick_r      <= tick_nxt;
      cmp_r       <= cmp_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    sec_r        <= sec_nxt;
    tag_in_r     <= tag_in_nxt;
    mode_add_r   <= mode_add_nxt;
    status_r     <= status_nxt;
    res_tag_r    <= res_tag_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_dl_r     <= out_dl_nxt;
    out_count_r  <= out_count_nxt;
  end

  // A new transaction is taken whenever no item is in work; a result still waiting
  // in the output register does not hold it back.
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'd0, out_count_r, out_dl_r, out_tag_r};

endmodule

`default_nettype wire

// ----- src/stq_checker.sv -----
// Port-level checker of the sorted timer event queue, bound to the top level.
// Uses stq_pkg and the macros of sorted_timer_event_queue_assert.svh.
`default_nettype none
`include "sorted_timer_event_queue_assert.svh"

module stq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import stq_pkg::*;

  localparam logic [4:0] DEPTH_LOW = 5'(QUEUE_DEPTH);

  // A stalled result keeps its contents.
  `STQ_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Only a fired event carries a tag.
  `STQ_ASSERT_IMP(a_tag_only_fired, out_tvalid && out_tuser != ST_FIRED,
                  out_tdata[7:0] == 8'd0)

  // A dropped add means the queue was full and stays full.
  `STQ_ASSERT_IMP(a_drop_full, out_tvalid && out_tuser == ST_DROPPED,
                  out_tdata[76:72] == DEPTH_LOW)

  // The idle timeout is armed only with nothing pending.
  `STQ_ASSERT_IMP(a_idle_empty, out_tvalid && out_tuser == ST_IDLE_REARM,
                  out_tdata[76:72] == 5'd0)

endmodule

bind sorted_timer_event_queue stq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_stq_checker (.*);

`default_nettype wire
